@@ hdl/bcpv_pkg.sv @@
// Shared constants, types and curve tables for the pack-voltage charge estimator.
`default_nettype none
package bcpv_pkg;

   localparam int PACK_W   = 17;
   localparam int COUNT_W  = 6;
   localparam int CHARGE_W = 14;
   localparam int SEG_W    = 4;
   localparam int OFFS_W   = 7;
   localparam int PCT_W    = 7;
   localparam int TRIAL_W  = COUNT_W + 1;

   localparam logic [COUNT_W-1:0]  COUNT_RESET     = 6'd12;
   localparam logic [PACK_W-1:0]   CURVE_LOW_MV    = 17'd3300;
   localparam logic [PACK_W-1:0]   CURVE_HIGH_MV   = 17'd4200;
   localparam logic [CHARGE_W-1:0] FULL_HUNDREDTHS = 14'd10000;
   localparam logic [CHARGE_W-1:0] PCT_SCALE       = 14'd100;
   localparam int                  INNER_POINTS    = 8;

   typedef struct packed {
      logic [COUNT_W-1:0] rem;
      logic [PACK_W-1:0]  work;
      logic [COUNT_W-1:0] divisor;
   } div_word_type;

   function automatic logic [PCT_W-1:0] curve_percent(input logic [SEG_W-1:0] idx);
      logic [PCT_W-1:0] pct;
      case (idx)
         4'd0:    pct = 7'd0;
         4'd1:    pct = 7'd3;
         4'd2:    pct = 7'd8;
         4'd3:    pct = 7'd15;
         4'd4:    pct = 7'd30;
         4'd5:    pct = 7'd48;
         4'd6:    pct = 7'd65;
         4'd7:    pct = 7'd80;
         4'd8:    pct = 7'd92;
         4'd9:    pct = 7'd100;
         default: pct = 7'd0;
      endcase
      return pct;
   endfunction

   function automatic logic [PACK_W-1:0] curve_mv(input logic [SEG_W-1:0] idx);
      logic [PACK_W-1:0] mv;
      case (idx)
         4'd0:    mv = 17'd3300;
         4'd1:    mv = 17'd3400;
         4'd2:    mv = 17'd3500;
         4'd3:    mv = 17'd3600;
         4'd4:    mv = 17'd3700;
         4'd5:    mv = 17'd3800;
         4'd6:    mv = 17'd3900;
         4'd7:    mv = 17'd4000;
         4'd8:    mv = 17'd4100;
         4'd9:    mv = 17'd4200;
         default: mv = 17'd4200;
      endcase
      return mv;
   endfunction

endpackage
`default_nettype wire

@@ hdl/bcpv_div_cell.sv @@
// One restoring-division cell: produces one quotient bit per word and passes it on.
`default_nettype none
module bcpv_div_cell (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire bcpv_pkg::div_word_type in_word,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output bcpv_pkg::div_word_type     out_word
);

   logic                               valid_ff, valid_in;
   bcpv_pkg::div_word_type             word_ff, word_in, step;
   logic [bcpv_pkg::TRIAL_W-1:0]       trial, diff;
   logic                               fits;
   logic                               load;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;

   always_comb begin
      trial        = {in_word.rem, in_word.work[bcpv_pkg::PACK_W-1]};
      diff         = trial - {1'b0, in_word.divisor};
      fits         = trial >= {1'b0, in_word.divisor};
      step.divisor = in_word.divisor;
      step.rem     = fits ? diff[bcpv_pkg::COUNT_W-1:0] : trial[bcpv_pkg::COUNT_W-1:0];
      step.work    = {in_word.work[bcpv_pkg::PACK_W-2:0], fits};
   end

   always_comb begin
      valid_in = load ? 1'b1 : (out_ready ? 1'b0 : valid_ff);
      word_in  = load ? step : word_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      word_ff <= word_in;
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule
`default_nettype wire

@@ hdl/bcpv_curve.sv @@
// Curve lookup and interpolation stages ending in the result register.
`default_nettype none
module bcpv_curve (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   output logic                               in_ready,
   input  wire bcpv_pkg::div_word_type        in_word,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [bcpv_pkg::CHARGE_W-1:0]      rsp_charge_hundredths,
   output logic [bcpv_pkg::PACK_W-1:0]        rsp_cell_millivolts
);

   // lookup stage
   logic                              s1_valid_ff, s1_valid_in;
   logic [bcpv_pkg::PACK_W-1:0]       s1_mv_ff, s1_mv_in;
   logic [bcpv_pkg::SEG_W-1:0]        s1_seg_ff, s1_seg_in;
   logic [bcpv_pkg::OFFS_W-1:0]       s1_offs_ff, s1_offs_in;
   logic                              s1_low_ff, s1_low_in;
   logic                              s1_high_ff, s1_high_in;
   logic                              s1_ready, s1_load;
   logic [bcpv_pkg::PACK_W-1:0]       cell_mv, offs_full;

   // result stage
   logic                              out_valid_ff, out_valid_in;
   logic [bcpv_pkg::CHARGE_W-1:0]     out_charge_ff, out_charge_in;
   logic [bcpv_pkg::PACK_W-1:0]       out_mv_ff, out_mv_in;
   logic                              out_ready, out_load;
   logic [bcpv_pkg::PCT_W-1:0]        pct_lo, pct_hi;
   logic [bcpv_pkg::CHARGE_W-1:0]     base, slope, interp;

   assign s1_ready = !s1_valid_ff || out_ready;
   assign in_ready = s1_ready;
   assign s1_load  = in_valid && s1_ready;

   always_comb begin
      cell_mv   = (in_word.divisor == '0) ? '0 : in_word.work;
      s1_seg_in = '0;
      for (int k = 1; k <= bcpv_pkg::INNER_POINTS; k++) begin
         if (cell_mv >= bcpv_pkg::curve_mv(bcpv_pkg::SEG_W'(k))) begin
            s1_seg_in = bcpv_pkg::SEG_W'(k);
         end
      end
      offs_full  = cell_mv - bcpv_pkg::curve_mv(s1_seg_in);
      s1_offs_in = offs_full[bcpv_pkg::OFFS_W-1:0];
      s1_low_in  = cell_mv <= bcpv_pkg::CURVE_LOW_MV;
      s1_high_in = cell_mv >= bcpv_pkg::CURVE_HIGH_MV;
      s1_mv_in   = cell_mv;
      s1_valid_in = s1_load ? 1'b1 : (out_ready ? 1'b0 : s1_valid_ff);
   end

   assign out_ready = !out_valid_ff || rsp_ready;
   assign out_load  = s1_valid_ff && out_ready;

   always_comb begin
      pct_lo = bcpv_pkg::curve_percent(s1_seg_ff);
      pct_hi = bcpv_pkg::curve_percent(s1_seg_ff + bcpv_pkg::SEG_W'(1));
      base   = bcpv_pkg::CHARGE_W'(pct_lo) * bcpv_pkg::PCT_SCALE;
      slope  = bcpv_pkg::CHARGE_W'(pct_hi - pct_lo);
      interp = base + bcpv_pkg::CHARGE_W'(s1_offs_ff) * slope;
      if (s1_low_ff) begin
         out_charge_in = '0;
      end else if (s1_high_ff) begin
         out_charge_in = bcpv_pkg::FULL_HUNDREDTHS;
      end else begin
         out_charge_in = interp;
      end
      out_mv_in    = s1_mv_ff;
      out_valid_in = out_load ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
      if (s1_load) begin
         s1_mv_ff   <= s1_mv_in;
         s1_seg_ff  <= s1_seg_in;
         s1_offs_ff <= s1_offs_in;
         s1_low_ff  <= s1_low_in;
         s1_high_ff <= s1_high_in;
      end
      if (out_load) begin
         out_charge_ff <= out_charge_in;
         out_mv_ff     <= out_mv_in;
      end
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_charge_hundredths = out_charge_ff;
   assign rsp_cell_millivolts   = out_mv_ff;

endmodule
`default_nettype wire

@@ hdl/battery_charge_from_pack_voltage.sv @@
// Top level: state of charge and cell voltage from a pack voltage sample.
// Each accepted pack voltage gives one result word through 17 division cells, one
// per quotient bit of the 17-bit cell voltage, then a curve lookup stage and the
// result register. One word is accepted every cycle while the receiver keeps up;
// the chain holds up to 19 words in flight and keeps filling while a result waits.
// Charge is linear between the 100 mV breakpoints of the lithium-ion curve,
// 0 at or below 3300 mV per cell and 10000 at or above 4200 mV. A cell count of
// zero gives zero cell voltage and zero charge. Write csr_wdata only when idle.
`default_nettype none
module battery_charge_from_pack_voltage (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [bcpv_pkg::PACK_W-1:0]       req_pack_millivolts,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [bcpv_pkg::CHARGE_W-1:0]          rsp_charge_hundredths,
   output logic [bcpv_pkg::PACK_W-1:0]            rsp_cell_millivolts,
   input  wire logic                              csr_we,
   input  wire logic [bcpv_pkg::COUNT_W-1:0]      csr_wdata
);

   logic [bcpv_pkg::COUNT_W-1:0] count_ff, count_in;
   bcpv_pkg::div_word_type       word  [bcpv_pkg::PACK_W+1];
   logic                         valid [bcpv_pkg::PACK_W+1];
   logic                         ready [bcpv_pkg::PACK_W+1];

   assign count_in = csr_we ? csr_wdata : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= bcpv_pkg::COUNT_RESET;
      end else begin
         count_ff <= count_in;
      end
   end

   assign word[0].rem     = '0;
   assign word[0].work    = req_pack_millivolts;
   assign word[0].divisor = count_ff;
   assign valid[0]        = req_valid;
   assign req_ready       = ready[0];

   for (genvar i = 0; i < bcpv_pkg::PACK_W; i++) begin : g_cell
      bcpv_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (valid[i]),
         .in_ready  (ready[i]),
         .in_word   (word[i]),
         .out_valid (valid[i+1]),
         .out_ready (ready[i+1]),
         .out_word  (word[i+1])
      );
   end

   bcpv_curve u_curve (
      .clock                 (clock),
      .reset                 (reset),
      .in_valid              (valid[bcpv_pkg::PACK_W]),
      .in_ready              (ready[bcpv_pkg::PACK_W]),
      .in_word               (word[bcpv_pkg::PACK_W]),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_charge_hundredths (rsp_charge_hundredths),
      .rsp_cell_millivolts   (rsp_cell_millivolts)
   );

`ifndef ASSERT_OFF
   a_charge_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_charge_hundredths <= bcpv_pkg::FULL_HUNDREDTHS)
      else $error("charge above full scale");

   a_low_clamp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_cell_millivolts <= bcpv_pkg::CURVE_LOW_MV
      |-> rsp_charge_hundredths == '0)
      else $error("charge not zero below curve");

   a_high_clamp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_cell_millivolts >= bcpv_pkg::CURVE_HIGH_MV
      |-> rsp_charge_hundredths == bcpv_pkg::FULL_HUNDREDTHS)
      else $error("charge not full above curve");

   a_fill_when_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready && !valid[1] |-> req_ready)
      else $error("input stalled with empty head cell");
`endif

endmodule
`default_nettype wire

@@ dv/bcpv_charge_checker.sv @@
// Checker: predicts charge and cell voltage for each accepted word and compares results.
module bcpv_charge_checker (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   input  wire logic                          req_ready,
   input  wire logic [bcpv_pkg::PACK_W-1:0]   req_pack_millivolts,
   input  wire logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   input  wire logic [bcpv_pkg::CHARGE_W-1:0] rsp_charge_hundredths,
   input  wire logic [bcpv_pkg::PACK_W-1:0]   rsp_cell_millivolts,
   input  wire logic                          csr_we,
   input  wire logic [bcpv_pkg::COUNT_W-1:0]  csr_wdata,
   output int                                 mismatches,
   output int                                 words_owed
);

   typedef struct packed {
      logic [bcpv_pkg::CHARGE_W-1:0] charge;
      logic [bcpv_pkg::PACK_W-1:0]   cell_mv;
   } soc_word_type;

   soc_word_type                 soc_due[$];
   soc_word_type                 due;
   logic [bcpv_pkg::COUNT_W-1:0] cells_cfg = bcpv_pkg::COUNT_RESET;
   int                           errs = 0;

   function automatic int unsigned soc_curve_pct(input int unsigned point);
      int unsigned pct;
      case (point)
         0:       pct = 0;
         1:       pct = 3;
         2:       pct = 8;
         3:       pct = 15;
         4:       pct = 30;
         5:       pct = 48;
         6:       pct = 65;
         7:       pct = 80;
         8:       pct = 92;
         default: pct = 100;
      endcase
      return pct;
   endfunction

   function automatic soc_word_type predict_soc(input logic [bcpv_pkg::PACK_W-1:0] pack,
                                                input logic [bcpv_pkg::COUNT_W-1:0] cells);
      soc_word_type w;
      int unsigned  cell_volt, above, seg, offs, lo, hi, charge;
      cell_volt = (cells == 0) ? 0 : 32'(pack) / 32'(cells);
      if (cell_volt <= 3300) begin
         charge = 0;
      end else if (cell_volt >= 4200) begin
         charge = 10000;
      end else begin
         above  = cell_volt - 3300;
         seg    = above / 100;
         offs   = above % 100;
         lo     = soc_curve_pct(seg);
         hi     = soc_curve_pct(seg + 1);
         charge = lo * 100 + offs * (hi - lo);
      end
      w.charge  = charge[bcpv_pkg::CHARGE_W-1:0];
      w.cell_mv = cell_volt[bcpv_pkg::PACK_W-1:0];
      return w;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         soc_due.delete();
         cells_cfg = bcpv_pkg::COUNT_RESET;
         words_owed <= 0;
      end else begin
         if (req_valid && req_ready)
            soc_due.push_back(predict_soc(req_pack_millivolts, cells_cfg));
         if (rsp_valid && rsp_ready) begin
            if (soc_due.size() == 0) begin
               errs++;
               if (errs <= 10)
                  $display("unexpected word: charge %0d cell_mv %0d",
                           rsp_charge_hundredths, rsp_cell_millivolts);
            end else begin
               due = soc_due.pop_front();
               if (due.charge !== rsp_charge_hundredths ||
                   due.cell_mv !== rsp_cell_millivolts) begin
                  errs++;
                  if (errs <= 10)
                     $display("mismatch: charge exp %0d got %0d, cell_mv exp %0d got %0d",
                              due.charge, rsp_charge_hundredths,
                              due.cell_mv, rsp_cell_millivolts);
               end
            end
         end
         if (csr_we)
            cells_cfg = csr_wdata;
         words_owed <= soc_due.size();
      end
      mismatches <= errs;
   end

endmodule

@@ dv/tb_top.sv @@
// Testbench top: clock, reset, stimulus and verdict for the pack-voltage charge estimator.
module tb_top;

   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 150;
   localparam int PHASES      = 8;
   localparam int PHASE_WORDS = 215;
   localparam int DIRECTED    = 20;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic [bcpv_pkg::PACK_W-1:0]   req_pack_millivolts = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic [bcpv_pkg::CHARGE_W-1:0] rsp_charge_hundredths;
   logic [bcpv_pkg::PACK_W-1:0]   rsp_cell_millivolts;
   logic                          csr_we = 1'b0;
   logic [bcpv_pkg::COUNT_W-1:0]  csr_wdata = '0;

   int mismatches;
   int words_owed;
   int cycles = 0;
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int hold_token = 0;
   int holds_taken = 0;

   int unsigned directed_words [DIRECTED] = '{
      0, 1, 131071, 65536, 65535, 39600, 39611, 39612, 40800, 41400,
      42000, 43200, 44400, 45600, 46800, 48000, 49200, 50388, 50400, 50411
   };
   int unsigned phase_cells [PHASES] = '{0, 1, 63, 32, 12, 7, 1, 3};

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   battery_charge_from_pack_voltage DUT (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_pack_millivolts   (req_pack_millivolts),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_charge_hundredths (rsp_charge_hundredths),
      .rsp_cell_millivolts   (rsp_cell_millivolts),
      .csr_we                (csr_we),
      .csr_wdata             (csr_wdata)
   );

   bcpv_charge_checker soc_check (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_pack_millivolts   (req_pack_millivolts),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_charge_hundredths (rsp_charge_hundredths),
      .rsp_cell_millivolts   (rsp_cell_millivolts),
      .csr_we                (csr_we),
      .csr_wdata             (csr_wdata),
      .mismatches            (mismatches),
      .words_owed            (words_owed)
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("battery_charge_from_pack_voltage regression: fail");
         $finish;
      end
   end

   // hold off the receiver for a long stretch on request, else stall at random
   always begin
      @(posedge clock);
      if (hold_token != holds_taken) begin
         holds_taken = hold_token;
         rsp_ready <= 1'b0;
         repeat (HOLD_CYCLES) @(posedge clock);
      end
      rsp_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
   end

   function automatic logic [bcpv_pkg::PACK_W-1:0] pick_pack(input int unsigned cells);
      int unsigned roll, cell_mv, pack;
      roll = $urandom_range(0, 99);
      if (roll < 20 || cells == 0) begin
         pack = $urandom_range(0, 131071);
      end else if (roll < 30) begin
         cell_mv = 3300 + 100 * $urandom_range(0, 9);
         pack = cell_mv * cells;
      end else begin
         cell_mv = $urandom_range(3250, 4250);
         pack = cell_mv * cells + $urandom_range(0, cells - 1);
      end
      if (pack > 131071)
         pack = $urandom_range(0, 131071);
      return pack[bcpv_pkg::PACK_W-1:0];
   endfunction

   task automatic send_word(input logic [bcpv_pkg::PACK_W-1:0] pack);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_pack_millivolts <= pack;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (words_owed != 0) @(posedge clock);
   endtask

   task automatic write_cells(input int unsigned cells);
      drain_results();
      csr_we    <= 1'b1;
      csr_wdata <= cells[bcpv_pkg::COUNT_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_words[i])
         send_word(directed_words[i][bcpv_pkg::PACK_W-1:0]);

      for (int p = 0; p < PHASES; p++) begin
         write_cells(phase_cells[p]);
         case (p % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct <= 0;  end
            1: begin sender_idle_pct = 65; receiver_stall_pct <= 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct <= 65; end
            default: begin sender_idle_pct = 29; receiver_stall_pct <= 29; end
         endcase
         for (int n = 0; n < PHASE_WORDS; n++) begin
            if (p == 0 && n == 40)
               hold_token <= hold_token + 1;
            if (p == 1 && n == PHASE_WORDS / 2)
               drain_results();
            send_word(pick_pack(phase_cells[p]));
         end
      end

      drain_results();
      repeat (25) @(posedge clock);
      if (mismatches == 0 && words_owed == 0)
         $display("battery_charge_from_pack_voltage regression: pass");
      else
         $display("battery_charge_from_pack_voltage regression: fail");
      $finish;
   end

endmodule
